/* design/script_byte_tokenizer_top_assert.svh */
// Assertion macros shared by the script byte tokenizer RTL.
// Expects clk and rst_n in the scope of the including module.
`ifndef SCRIPT_BYTE_TOKENIZER_TOP_ASSERT_SVH
`define SCRIPT_BYTE_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SBT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sbt_pkg.sv */
// Shared constants and types for the script byte tokenizer.
// No dependencies.
package sbt_pkg;

  // Result kinds
  localparam logic [2:0] KIND_PREFIX   = 3'd0;
  localparam logic [2:0] KIND_PLAIN_OP = 3'd1;
  localparam logic [2:0] KIND_PUSH_OP  = 3'd2;
  localparam logic [2:0] KIND_PUSH_LEN = 3'd3;
  localparam logic [2:0] KIND_PUSH_DAT = 3'd4;
  localparam logic [2:0] KIND_IGNORED  = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_PUSH_LONG = 2'd1;
  localparam logic [1:0] ERR_PAST_END  = 2'd2;
  localparam logic [1:0] ERR_VARINT    = 2'd3;

  // Opcodes and varint markers
  localparam logic [7:0] MAX_DIRECT_PUSH = 8'd75;
  localparam logic [7:0] OP_PUSHDATA1    = 8'd76;
  localparam logic [7:0] OP_PUSHDATA2    = 8'd77;
  localparam logic [7:0] VARINT_2B       = 8'hFD;
  localparam logic [7:0] VARINT_4B       = 8'hFE;

  // Configuration
  localparam logic [15:0] MAX_PUSH_RESET = 16'd520;
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_MAX_PUSH = 3'd0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_out;
    logic [15:0] push_len;
    logic        end_of_command;
    logic        end_of_script;
    logic [1:0]  error;
  } sbt_result_t;

endpackage

/* design/script_byte_tokenizer_top.sv */
// Top level of the script byte tokenizer: input stage, parser, result stage.
// Depends on sbt_pkg, sbt_cfg_regs, sbt_parser and script_byte_tokenizer_top_assert.svh.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-----------------------------------------------
//  in_     | in  | tvalid / tready   | tdata = byte_value, tuser = start_script
//  out_    | out | tvalid / tready   | tdata = byte_out, push_len, eoc, error;
//          |     |                   | tuser = kind, tlast = end_of_script
//  cfg_    | in  | APB psel/penable  | reg 0 max_push_len at byte address 0
//
// One byte per cycle sustained while out_tready holds; each byte passes two registers
// (input register, then result register). The rate is set by the parser, which updates its state once per byte.
// Reset is synchronous, active low; it clears both stage valids and parser state and
// loads max_push_len with 520. An output stall backs up through the input stage; while
// a result waits, one more byte is taken only if the input register is empty.
module script_byte_tokenizer_top
  import sbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] byte_value
  input  logic                  in_tuser,   // [0] start_script
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [7:0] byte_out, [23:8] push_len,
                                            // [24] end_of_command, [26:25] error, rest 0
  output logic [2:0]            out_tuser,  // [2:0] kind
  output logic                  out_tlast,  // end_of_script
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;
  logic        out_valid_r;
  sbt_result_t res_r;
  sbt_result_t res_nxt;
  logic [15:0] max_push_len;
  logic        advance;
  logic        in_xfer;

  // Config registers
  sbt_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .max_push_len (max_push_len)
  );

  // Stage 1 moves into the result register when that register is free or draining
  assign advance   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | advance;
  assign in_xfer   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // Parser state commits on the same edge the result is captured
  sbt_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .byte_in      (s1_byte_r),
    .start_in     (s1_start_r),
    .max_push_len (max_push_len),
    .result       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.error, res_r.end_of_command, res_r.push_len,
                       res_r.byte_out};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.end_of_script;

`include "script_byte_tokenizer_top_assert.svh"

  // An error never closes a command or a script
  `SBT_ASSERT_IMPL(a_err_no_marks, out_valid_r && res_r.error != ERR_NONE, !res_r.end_of_command && !res_r.end_of_script, "error with end mark")
  // Script end is either an empty-count prefix or the end of a command
  `SBT_ASSERT_IMPL(a_eos_source, out_valid_r && res_r.end_of_script, res_r.end_of_command || res_r.kind == KIND_PREFIX, "stray end of script")
  // Ignored bytes carry no length and no error
  `SBT_ASSERT_IMPL(a_ignored_clean, out_valid_r && res_r.kind == KIND_IGNORED, res_r.push_len == 16'd0 && res_r.error == ERR_NONE, "ignored byte with payload")
  // A stalled result with a full input stage blocks new input
  `SBT_ASSERT_NEXT(a_full_blocks, s1_valid_r && out_valid_r && !out_tready, s1_valid_r && out_valid_r, "pipeline dropped an item")

endmodule

/* design/sbt_cfg_regs.sv */
// APB-style configuration register block for the script byte tokenizer.
// Depends on sbt_pkg.
module sbt_cfg_regs
  import sbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output logic [15:0]           max_push_len
);

  logic [15:0] max_push_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_push_r <= MAX_PUSH_RESET;
    end else if (wr_en && cfg_paddr == CFG_ADDR_MAX_PUSH) begin
      max_push_r <= cfg_pwdata[15:0];
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr == CFG_ADDR_MAX_PUSH) begin
      cfg_prdata = {16'd0, max_push_r};
    end
  end

  assign max_push_len = max_push_r;

endmodule

/* design/sbt_parser.sv */
// Parser state and per-byte classification logic.
// Depends on sbt_pkg and script_byte_tokenizer_top_assert.svh.
module sbt_parser
  import sbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  byte_in,
  input  logic        start_in,
  input  logic [15:0] max_push_len,
  output sbt_result_t result
);

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_PRE2   = 8'b0000_0010,
    PH_PRE4   = 8'b0000_0100,
    PH_OPCODE = 8'b0000_1000,
    PH_LEN1   = 8'b0001_0000,
    PH_LEN2LO = 8'b0010_0000,
    PH_LEN2HI = 8'b0100_0000,
    PH_DATA   = 8'b1000_0000
  } sbt_phase_t;

  sbt_phase_t  phase_r, phase_nxt;
  logic [31:0] script_rem_r, script_rem_nxt;
  logic [15:0] push_rem_r, push_rem_nxt;
  logic [31:0] len_acc_r, len_acc_nxt;
  logic [2:0]  pre_left_r, pre_left_nxt;

  logic [31:0] sr_dec;
  logic [15:0] pr_dec;
  logic [2:0]  pre_total;
  logic [2:0]  pre_left_eff;
  logic [2:0]  pre_pos;
  logic [31:0] acc_full;
  logic        do_push;
  logic [15:0] push_n;

  assign sr_dec = (script_rem_r != 32'd0) ? script_rem_r - 32'd1 : 32'd0;
  assign pr_dec = (push_rem_r != 16'd0) ? push_rem_r - 16'd1 : 16'd0;

  // Varint byte position within the multi-byte count
  assign pre_total    = (phase_r == PH_PRE2) ? 3'd2 : 3'd4;
  assign pre_left_eff = (pre_left_r == 3'd0 || pre_left_r > pre_total) ? pre_total
                                                                       : pre_left_r;
  assign pre_pos      = pre_total - pre_left_eff;
  assign acc_full     = len_acc_r | ({24'd0, byte_in} << {pre_pos[1:0], 3'b000});

  always_comb begin
    phase_nxt      = phase_r;
    script_rem_nxt = script_rem_r;
    push_rem_nxt   = push_rem_r;
    len_acc_nxt    = len_acc_r;
    pre_left_nxt   = pre_left_r;
    do_push        = 1'b0;
    push_n         = 16'd0;

    result                = '0;
    result.kind           = KIND_IGNORED;
    result.byte_out       = byte_in;
    result.error          = ERR_NONE;

    if (start_in) begin
      result.kind  = KIND_PREFIX;
      len_acc_nxt  = 32'd0;
      push_rem_nxt = 16'd0;
      if (byte_in < VARINT_2B) begin
        script_rem_nxt = {24'd0, byte_in};
        pre_left_nxt   = 3'd0;
        if (byte_in == 8'd0) begin
          result.end_of_script = 1'b1;
          phase_nxt            = PH_IDLE;
        end else begin
          phase_nxt = PH_OPCODE;
        end
      end else if (byte_in == VARINT_2B) begin
        pre_left_nxt = 3'd2;
        phase_nxt    = PH_PRE2;
      end else if (byte_in == VARINT_4B) begin
        pre_left_nxt = 3'd4;
        phase_nxt    = PH_PRE4;
      end else begin
        result.error = ERR_VARINT;
        pre_left_nxt = 3'd0;
        phase_nxt    = PH_IDLE;
      end
    end else if (phase_r == PH_PRE2 || phase_r == PH_PRE4) begin
      result.kind  = KIND_PREFIX;
      len_acc_nxt  = acc_full;
      pre_left_nxt = pre_left_eff - 3'd1;
      if (pre_left_eff == 3'd1) begin
        script_rem_nxt = acc_full;
        len_acc_nxt    = 32'd0;
        if (acc_full == 32'd0) begin
          result.end_of_script = 1'b1;
          phase_nxt            = PH_IDLE;
        end else begin
          phase_nxt = PH_OPCODE;
        end
      end
    end else if (phase_r != PH_IDLE) begin
      script_rem_nxt = sr_dec;
      case (phase_r)
        PH_OPCODE: begin
          if (byte_in inside {[8'd1:MAX_DIRECT_PUSH]}) begin
            result.kind     = KIND_PUSH_OP;
            result.push_len = {8'd0, byte_in};
            do_push         = 1'b1;
            push_n          = {8'd0, byte_in};
          end else if (byte_in == OP_PUSHDATA1) begin
            result.kind = KIND_PUSH_OP;
            if (sr_dec < 32'd1) begin
              result.error = ERR_PAST_END;
              phase_nxt    = PH_IDLE;
            end else begin
              phase_nxt = PH_LEN1;
            end
          end else if (byte_in == OP_PUSHDATA2) begin
            result.kind = KIND_PUSH_OP;
            if (sr_dec < 32'd2) begin
              result.error = ERR_PAST_END;
              phase_nxt    = PH_IDLE;
            end else begin
              phase_nxt = PH_LEN2LO;
            end
          end else begin
            result.kind           = KIND_PLAIN_OP;
            result.end_of_command = 1'b1;
            if (sr_dec == 32'd0) begin
              result.end_of_script = 1'b1;
              phase_nxt            = PH_IDLE;
            end
          end
        end
        PH_LEN1: begin
          result.kind     = KIND_PUSH_LEN;
          result.push_len = {8'd0, byte_in};
          do_push         = 1'b1;
          push_n          = {8'd0, byte_in};
        end
        PH_LEN2LO: begin
          result.kind = KIND_PUSH_LEN;
          len_acc_nxt = {24'd0, byte_in};
          phase_nxt   = PH_LEN2HI;
        end
        PH_LEN2HI: begin
          result.kind     = KIND_PUSH_LEN;
          result.push_len = {byte_in, len_acc_r[7:0]};
          do_push         = 1'b1;
          push_n          = {byte_in, len_acc_r[7:0]};
        end
        PH_DATA: begin
          result.kind     = KIND_PUSH_DAT;
          result.push_len = len_acc_r[15:0];
          push_rem_nxt    = pr_dec;
          if (pr_dec == 16'd0) begin
            result.end_of_command = 1'b1;
            if (sr_dec == 32'd0) begin
              result.end_of_script = 1'b1;
              phase_nxt            = PH_IDLE;
            end else begin
              phase_nxt = PH_OPCODE;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // Push length known: check limits, then open the data run or, for length 0, end the command
    if (do_push) begin
      if (push_n > max_push_len) begin
        result.error = ERR_PUSH_LONG;
        phase_nxt    = PH_IDLE;
      end else if ({16'd0, push_n} > sr_dec) begin
        result.error = ERR_PAST_END;
        phase_nxt    = PH_IDLE;
      end else begin
        len_acc_nxt  = {16'd0, push_n};
        push_rem_nxt = push_n;
        if (push_n == 16'd0) begin
          result.end_of_command = 1'b1;
          if (sr_dec == 32'd0) begin
            result.end_of_script = 1'b1;
            phase_nxt            = PH_IDLE;
          end else begin
            phase_nxt = PH_OPCODE;
          end
        end else begin
          phase_nxt = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      script_rem_r <= 32'd0;
      push_rem_r   <= 16'd0;
      len_acc_r    <= 32'd0;
      pre_left_r   <= 3'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      script_rem_r <= script_rem_nxt;
      push_rem_r   <= push_rem_nxt;
      len_acc_r    <= len_acc_nxt;
      pre_left_r   <= pre_left_nxt;
    end
  end

`include "script_byte_tokenizer_top_assert.svh"

  // Pending push data exists only inside a data run
  `SBT_ASSERT_IMPL(a_push_rem_in_data, push_rem_r != 16'd0, phase_r == PH_DATA, "push count outside data run")

endmodule

/* verif/sbt_token_checker.sv */
`timescale 1ns / 1ps
// Checker for the script byte tokenizer: watches the input, result and config ports,
// predicts one token per accepted byte and compares each result transfer against it.
// Depends on sbt_pkg.
module sbt_token_checker
  import sbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [31:0]           out_tdata,
  input  logic [2:0]            out_tuser,
  input  logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    tokens_due,
  output int                    fail_count
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_PRE2   = 8'b0000_0010,
    ST_PRE4   = 8'b0000_0100,
    ST_OPCODE = 8'b0000_1000,
    ST_LEN1   = 8'b0001_0000,
    ST_LEN2LO = 8'b0010_0000,
    ST_LEN2HI = 8'b0100_0000,
    ST_DATA   = 8'b1000_0000
  } parse_state_t;

  parse_state_t pstate;
  logic [31:0]  script_left;
  logic [15:0]  push_left;
  logic [31:0]  len_acc;      // varint gather, then the current push length
  logic [2:0]   prefix_left;
  logic [15:0]  push_limit;

  sbt_result_t  token_q[$];
  int           mismatches = 0;

  assign fail_count = mismatches;

  // Starts a push of known length n; returns the error code.
  function automatic logic [1:0] open_push(input logic [31:0] n, output logic eoc,
                                           output logic eos);
    eoc = 1'b0;
    eos = 1'b0;
    if (n > {16'd0, push_limit}) begin
      pstate = ST_IDLE;
      return ERR_PUSH_LONG;
    end
    if (n > script_left) begin
      pstate = ST_IDLE;
      return ERR_PAST_END;
    end
    len_acc   = n;
    push_left = n[15:0];
    if (n == 32'd0) begin
      eoc = 1'b1;
      if (script_left == 32'd0) begin
        eos    = 1'b1;
        pstate = ST_IDLE;
      end else begin
        pstate = ST_OPCODE;
      end
    end else begin
      pstate = ST_DATA;
    end
    return ERR_NONE;
  endfunction

  function automatic sbt_result_t classify_byte(input logic [7:0] b, input logic start);
    sbt_result_t r;
    logic [31:0] total;
    logic [31:0] left;
    logic [31:0] n;
    logic        eoc;
    logic        eos;
    r          = '0;
    r.kind     = KIND_IGNORED;
    r.byte_out = b;
    eoc        = 1'b0;
    eos        = 1'b0;
    if (start) begin
      // restart in any state
      r.kind    = KIND_PREFIX;
      len_acc   = '0;
      push_left = '0;
      if (b < VARINT_2B) begin
        script_left = {24'd0, b};
        prefix_left = '0;
        if (b == 8'd0) begin
          eos    = 1'b1;
          pstate = ST_IDLE;
        end else begin
          pstate = ST_OPCODE;
        end
      end else if (b == VARINT_2B) begin
        prefix_left = 3'd2;
        pstate      = ST_PRE2;
      end else if (b == VARINT_4B) begin
        prefix_left = 3'd4;
        pstate      = ST_PRE4;
      end else begin
        r.error     = ERR_VARINT;
        prefix_left = '0;
        pstate      = ST_IDLE;
      end
    end else if (pstate == ST_PRE2 || pstate == ST_PRE4) begin
      total = (pstate == ST_PRE2) ? 32'd2 : 32'd4;
      left  = {29'd0, prefix_left};
      if (left == 32'd0 || left > total) left = total;
      r.kind      = KIND_PREFIX;
      len_acc     = len_acc | ({24'd0, b} << (8 * (total - left)));
      prefix_left = 3'(left - 32'd1);
      if (left == 32'd1) begin
        script_left = len_acc;
        len_acc     = '0;
        if (script_left == 32'd0) begin
          eos    = 1'b1;
          pstate = ST_IDLE;
        end else begin
          pstate = ST_OPCODE;
        end
      end
    end else if (pstate != ST_IDLE) begin
      if (script_left != 32'd0) script_left = script_left - 32'd1;
      case (pstate)
        ST_OPCODE: begin
          if (b >= 8'd1 && b <= MAX_DIRECT_PUSH) begin
            r.kind     = KIND_PUSH_OP;
            r.push_len = {8'd0, b};
            r.error    = open_push({24'd0, b}, eoc, eos);
          end else if (b == OP_PUSHDATA1) begin
            r.kind = KIND_PUSH_OP;
            if (script_left < 32'd1) begin
              r.error = ERR_PAST_END;
              pstate  = ST_IDLE;
            end else begin
              pstate = ST_LEN1;
            end
          end else if (b == OP_PUSHDATA2) begin
            r.kind = KIND_PUSH_OP;
            if (script_left < 32'd2) begin
              r.error = ERR_PAST_END;
              pstate  = ST_IDLE;
            end else begin
              pstate = ST_LEN2LO;
            end
          end else begin
            r.kind = KIND_PLAIN_OP;
            eoc    = 1'b1;
            if (script_left == 32'd0) begin
              eos    = 1'b1;
              pstate = ST_IDLE;
            end
          end
        end
        ST_LEN1: begin
          r.kind     = KIND_PUSH_LEN;
          r.push_len = {8'd0, b};
          r.error    = open_push({24'd0, b}, eoc, eos);
        end
        ST_LEN2LO: begin
          r.kind  = KIND_PUSH_LEN;
          len_acc = {24'd0, b};
          pstate  = ST_LEN2HI;
        end
        ST_LEN2HI: begin
          n          = {16'd0, b, len_acc[7:0]};
          r.kind     = KIND_PUSH_LEN;
          r.push_len = n[15:0];
          r.error    = open_push(n, eoc, eos);
        end
        default: begin
          r.kind     = KIND_PUSH_DAT;
          r.push_len = len_acc[15:0];
          if (push_left != 16'd0) push_left = push_left - 16'd1;
          if (push_left == 16'd0) begin
            eoc = 1'b1;
            if (script_left == 32'd0) begin
              eos    = 1'b1;
              pstate = ST_IDLE;
            end else begin
              pstate = ST_OPCODE;
            end
          end
        end
      endcase
    end
    r.end_of_command = eoc;
    r.end_of_script  = eos;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    sbt_result_t want;
    if (!rst_n) begin
      pstate      = ST_IDLE;
      script_left = '0;
      push_left   = '0;
      len_acc     = '0;
      prefix_left = '0;
      push_limit  = MAX_PUSH_RESET;
      token_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (token_q.size() == 0) begin
          $error("result transfer with no token pending, tdata %h", out_tdata);
          mismatches++;
        end else begin
          want = token_q.pop_front();
          compare_field("kind", 16'(want.kind), 16'(out_tuser));
          compare_field("byte_out", 16'(want.byte_out), 16'(out_tdata[7:0]));
          compare_field("push_len", want.push_len, out_tdata[23:8]);
          compare_field("end_of_command", 16'(want.end_of_command), 16'(out_tdata[24]));
          compare_field("error", 16'(want.error), 16'(out_tdata[26:25]));
          compare_field("end_of_script", 16'(want.end_of_script), 16'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) token_q = {token_q, classify_byte(in_tdata, in_tuser)};
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == CFG_ADDR_MAX_PUSH) push_limit = cfg_pwdata[15:0];
    end
    tokens_due <= token_q.size();
  end

endmodule

/* verif/script_byte_tokenizer_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for script_byte_tokenizer_top: clock, reset, byte stimulus, APB writes
// and the verdict. Depends on sbt_pkg, the RTL and sbt_token_checker.
module script_byte_tokenizer_top_tb;
  import sbt_pkg::*;

  // Longest run of cycles without any transfer before the run is called hung.
  // The long receiver hold-off below is the worst legal case, so this sits well above.
  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  // Two register stages inside; the pipe is left to settle before the config port is touched.
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 190;

  typedef struct {
    logic [7:0] value;
    logic       first;
  } script_byte_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = '0;   // [7:0] byte_value
  logic                  in_tuser    = 1'b0; // [0] start_script
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [31:0]           out_tdata;          // [7:0] byte_out, [23:8] push_len,
                                             // [24] end_of_command, [26:25] error
  logic [2:0]            out_tuser;          // [2:0] kind
  logic                  out_tlast;          // end_of_script
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int          tokens_due;
  int          fail_count;
  int unsigned send_idle_pct = 0;   // chance per item of an idle cycle before it
  int unsigned stall_pct     = 0;   // chance per cycle of out_tready low
  logic        hold_req      = 1'b0;
  int          quiet_cycles  = 0;

  script_byte_t script_q[$];

  script_byte_tokenizer_top i_dut (.*);

  sbt_token_checker i_checker (.*);

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  // Result side. A hold-off request parks out_tready low while a countdown loaded from
  // HOLD_CYCLES runs here, so the two internal stages fill and in_tready drops.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Hang detector: any transfer on any port restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("script_byte_tokenizer_top_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_byte(input logic [7:0] value, input logic first);
    script_byte_t item;
    item.value = value;
    item.first = first;
    script_q   = {script_q, item};
  endtask

  // One transfer on the input side, with random idle cycles ahead of it.
  task automatic send_item(input script_byte_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item.value;
    in_tuser  <= item.first;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_queued();
    while (script_q.size() > 0) send_item(script_q.pop_front());
  endtask

  // Stop offering, let every pending token come out, then let the pipe settle.
  // The first edge lets the checker count the last accepted byte.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tokens_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_push_limit(input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_MAX_PUSH;
    cfg_pwdata  <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Queues one script: a random body of commands, a varint count in front of it.
  // Most scripts are well formed; the rest carry a wrong count, a damaged body byte,
  // a huge 4-byte count that never runs out, or an oversized 0xFF varint marker.
  task automatic build_script();
    logic [7:0]  body[$];
    logic [7:0]  op;
    logic [31:0] declared;
    int unsigned n;
    int unsigned flaw;
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // plain opcode: anything outside the push range, 0 included
          do op = 8'($urandom_range(0, 255)); while (op >= 8'd1 && op <= OP_PUSHDATA2);
          body = {body, op};
        end
        3, 4, 5: begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, MAX_DIRECT_PUSH)
                                           : $urandom_range(1, 12);
          body = {body, 8'(n)};
          repeat (n) body = {body, 8'($urandom)};
        end
        6, 7: begin
          n = ($urandom_range(0, 31) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
          body = {body, OP_PUSHDATA1, 8'(n)};
          repeat (n) body = {body, 8'($urandom)};
        end
        default: begin
          body = {body, OP_PUSHDATA2};
          if ($urandom_range(0, 7) == 0) begin
            // arbitrary 16-bit length with no data behind it
            n    = $urandom_range(0, 65535);
            body = {body, 8'(n), 8'(n >> 8)};
          end else begin
            n    = $urandom_range(0, 16);
            body = {body, 8'(n), 8'(n >> 8)};
            repeat (n) body = {body, 8'($urandom)};
          end
        end
      endcase
    end

    declared = body.size();
    flaw     = $urandom_range(0, 19);
    case (flaw)
      0, 1: declared = $urandom_range(0, body.size() + 3);
      2:    body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
      3:    declared = $urandom;
      default: ;
    endcase

    // stray byte ahead of the script: ignored when idle, else parsed mid-script
    if ($urandom_range(0, 9) == 0) add_byte(8'($urandom), 1'b0);

    if (flaw == 4) begin
      add_byte(8'hFF, 1'b1);
    end else if (flaw == 3 || $urandom_range(0, 9) == 0) begin
      add_byte(VARINT_4B, 1'b1);
      for (int i = 0; i < 4; i++) add_byte(declared[8*i +: 8], 1'b0);
    end else if (declared >= 32'(VARINT_2B) || $urandom_range(0, 9) < 2) begin
      // non-minimal 2-byte form is legal for short scripts too
      add_byte(VARINT_2B, 1'b1);
      add_byte(declared[7:0], 1'b0);
      add_byte(declared[15:8], 1'b0);
    end else begin
      add_byte(declared[7:0], 1'b1);
    end
    foreach (body[i]) add_byte(body[i], 1'b0);
  endtask

  // One random phase: new limit written while idle, new idle profile, optional
  // long receiver hold-off, then a batch of scripts.
  task automatic run_phase(input logic [15:0] limit, input int unsigned send_pct,
                           input int unsigned stall, input logic hold_off);
    drain();
    write_push_limit(limit);
    send_idle_pct = send_pct;
    stall_pct     = stall;
    if (hold_off) hold_req = 1'b1;
    while (script_q.size() < PHASE_ITEMS) build_script();
    send_queued();
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset limit of 520, no idling.
    add_byte(8'h00, 1'b0);              // byte while idle: ignored
    add_byte(8'h00, 1'b1);              // empty script
    add_byte(8'hFF, 1'b1);              // 8-byte varint marker: oversized count
    add_byte(VARINT_2B, 1'b1);          // 2-byte count of 5
    add_byte(8'h05, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);              //   plain opcode 0
    add_byte(8'h01, 1'b0);              //   direct push of 1
    add_byte(8'hFF, 1'b0);              //   its data byte ends the command
    add_byte(OP_PUSHDATA1, 1'b0);       //   PUSHDATA1 of length 0 ends command and script
    add_byte(8'h00, 1'b0);
    add_byte(8'h03, 1'b1);              // PUSHDATA2 of length 0
    add_byte(OP_PUSHDATA2, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h03, 1'b1);              // PUSHDATA2 of 521: one above the limit
    add_byte(OP_PUSHDATA2, 1'b0);
    add_byte(8'h09, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h02, 1'b1);              // push of 75 with one byte left: past the end
    add_byte(MAX_DIRECT_PUSH, 1'b0);
    add_byte(8'h01, 1'b1);              // PUSHDATA1 as the last byte: length runs past end
    add_byte(OP_PUSHDATA1, 1'b0);
    send_queued();

    // Random phases across limits and idle profiles. The first one also parks the
    // receiver for a long stretch while the sender keeps offering.
    run_phase(16'hFFFF, 0, 0, 1'b1);
    run_phase(16'h0000, 71, 0, 1'b0);
    run_phase(16'($urandom_range(8, 40)), 0, 71, 1'b0);
    run_phase(MAX_PUSH_RESET, 26, 26, 1'b0);
    run_phase(16'($urandom_range(0, 65535)), 0, 0, 1'b0);

    drain();
    if (fail_count == 0) begin
      $display("script_byte_tokenizer_top_tb OK");
    end else begin
      $display("script_byte_tokenizer_top_tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/sbt_pkg.sv
design/sbt_cfg_regs.sv
design/sbt_parser.sv
design/script_byte_tokenizer_top.sv
verif/sbt_token_checker.sv
verif/script_byte_tokenizer_top_tb.sv
